[rtl/drp_pkg.sv]
// Shared types and constants for the debounced rotator panel.
package drp_pkg;

    // Number of button channels
    localparam int Chans = 4;

    // Field widths
    localparam int AgeW   = 8;
    localparam int StepW  = 10;
    localparam int SpeedW = 16;

    // Age counter saturation value
    localparam logic [AgeW-1:0] AgeTop = '1;

    // Register reset values
    localparam logic [AgeW-1:0]   DebounceRst = 8'd20;
    localparam logic [StepW-1:0]  StepRst     = 10'd30;
    localparam logic [SpeedW-1:0] SpeedMaxRst = 16'hFFFF;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_DEBOUNCE  = 2'd0,
        CFG_STEP      = 2'd1,
        CFG_SPEED_MAX = 2'd2
    } t_cfg_idx;

    // What one lane reports for the current sample
    typedef struct packed {
        logic fire;   // stable level changed on this sample
        logic level;  // stable level after this sample
    } t_lane_evt;

    // One result beat
    typedef struct packed {
        logic              run_enable;
        logic              direction;
        logic [SpeedW-1:0] speed_value;
        logic [Chans-1:0]  stable_buttons;
    } t_result;

endpackage

[rtl/drp_lane.sv]
// One debounce lane: age counter, previous raw level and stable level of a channel.
module drp_lane (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_raw,
    input  logic                     i_tick,
    input  logic [drp_pkg::AgeW-1:0] i_debounce,
    output drp_pkg::t_lane_evt       o_evt
);
    import drp_pkg::*;

    logic            r_prev;
    logic            r_stable;
    logic [AgeW-1:0] r_age;
    logic [AgeW-1:0] n_age;
    logic            fire;

    // Clear the age on a raw change, otherwise advance it on a tick
    always_comb begin
        if (i_raw != r_prev) begin
            n_age = '0;
        end else if (i_tick && (r_age != AgeTop)) begin
            n_age = r_age + 1'b1;
        end else begin
            n_age = r_age;
        end
        fire = (n_age > i_debounce) && (i_raw != r_stable);
    end

    assign o_evt.fire  = fire;
    assign o_evt.level = fire ? i_raw : r_stable;

    // Hold lane state between accepted beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= 1'b0;
            r_stable <= 1'b0;
            r_age    <= '0;
        end else if (i_en) begin
            r_prev   <= i_raw;
            r_stable <= o_evt.level;
            r_age    <= n_age;
        end
    end

    a_age_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && (i_raw != r_prev)) |=> (r_age == '0))
        else $error("age not cleared after raw change");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> ($stable(r_age) && $stable(r_stable) && $stable(r_prev)))
        else $error("lane state moved without an accepted beat");

    a_fire_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && fire) |=> (r_stable == r_prev))
        else $error("stable level does not follow raw after a debounced change");

endmodule

[rtl/drp_merge.sv]
// Merge stage: applies the button rules of the firing lanes in channel order.
module drp_merge (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  drp_pkg::t_lane_evt         i_evt [drp_pkg::Chans],
    input  logic [drp_pkg::StepW-1:0]  i_step,
    input  logic [drp_pkg::SpeedW-1:0] i_speed_max,
    output drp_pkg::t_result           o_result
);
    import drp_pkg::*;

    logic [SpeedW-1:0] r_speed;
    logic              r_dir;
    logic              r_run;
    logic [SpeedW-1:0] n_speed;
    logic              n_dir;
    logic              n_run;
    logic [Chans-1:0]  snap;
    logic [SpeedW:0]   sum;
    logic [SpeedW-1:0] step_ext;
    logic [Chans-1:0]  fires;

    assign step_ext = {{(SpeedW-StepW){1'b0}}, i_step};

    // Walk the lanes in order; each firing lane sees the levels of lanes up to
    // itself after the update and the later lanes before it
    always_comb begin
        n_speed = r_speed;
        n_dir   = r_dir;
        n_run   = r_run;
        snap    = '0;
        sum     = '0;
        for (int k = 0; k < Chans; k++) begin
            if (i_evt[k].fire) begin
                for (int j = 0; j < Chans; j++) begin
                    snap[j] = (j <= k) ? i_evt[j].level : (i_evt[j].level ^ i_evt[j].fire);
                end
                sum = {1'b0, n_speed} + {1'b0, step_ext};
                if (!snap[0]) begin
                    n_speed = (sum > {1'b0, i_speed_max}) ? i_speed_max : sum[SpeedW-1:0];
                end else if (!snap[1]) begin
                    n_speed = (n_speed >= step_ext) ? (n_speed - step_ext) : '0;
                end else if (!snap[2]) begin
                    n_dir = ~n_dir;
                end else if (!snap[3]) begin
                    n_run = ~n_run;
                end
            end
        end
    end

    // Build the result from the updated state
    always_comb begin
        for (int j = 0; j < Chans; j++) begin
            o_result.stable_buttons[j] = i_evt[j].level;
            fires[j]                   = i_evt[j].fire;
        end
        o_result.run_enable  = n_run;
        o_result.direction   = n_dir;
        o_result.speed_value = n_speed;
    end

    // Hold control state between accepted beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= '0;
            r_dir   <= 1'b0;
            r_run   <= 1'b1;
        end else if (i_en) begin
            r_speed <= n_speed;
            r_dir   <= n_dir;
            r_run   <= n_run;
        end
    end

    a_no_fire_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_en || (fires == '0)) |=> ($stable(r_speed) && $stable(r_dir) && $stable(r_run)))
        else $error("control state changed without a debounced event");

    a_one_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(fires) <= 1) |-> !((n_dir != r_dir) && (n_run != r_run)))
        else $error("single event toggled both direction and run");

    a_speed_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && (n_speed != r_speed) && (n_speed > r_speed)) |-> (n_speed <= i_speed_max))
        else $error("speed raised past its limit");

endmodule

[rtl/drp_out_fifo.sv]
// Two-entry result queue that decouples the output stall from input acceptance.
module drp_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  drp_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_stall,
    output drp_pkg::t_result o_data
);
    import drp_pkg::*;

    t_result     r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && !i_stall;

    // Store an incoming beat
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue occupancy out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("beat pushed into a full queue");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_count == 2'd0) || (r_count == 2'd2)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with occupancy");

endmodule

[rtl/debounced_rotator_panel.sv]
// Top level of the debounced rotator panel: config registers, lanes, merge and result queue.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------------------------
//  in       | i_in_valid  / o_in_stall     | i_raw_buttons, i_ms_tick
//  out      | o_out_valid / i_out_stall    | o_run_enable, o_direction, o_speed_value,
//           |                              | o_stable_buttons
//  cfg      | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
//  One sample per cycle while o_in_stall is low; its result is queued when it is accepted.
//  The four lanes and the in-order rule merge update state in the accept cycle.
//  A two-entry result queue lets input keep flowing while one result waits;
//  o_in_stall rises only when both entries are occupied.
//  Synchronous active-low reset; no clearing pass, the block is ready right after it.
module debounced_rotator_panel (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [drp_pkg::Chans-1:0]  i_raw_buttons,
    input  logic                       i_ms_tick,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_run_enable,
    output logic                       o_direction,
    output logic [drp_pkg::SpeedW-1:0] o_speed_value,
    output logic [drp_pkg::Chans-1:0]  o_stable_buttons,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [drp_pkg::SpeedW-1:0] i_cfg_data
);
    import drp_pkg::*;

    logic [AgeW-1:0]   r_debounce;
    logic [StepW-1:0]  r_step;
    logic [SpeedW-1:0] r_speed_max;
    logic              accept;
    logic              full;
    t_lane_evt         evt [Chans];
    t_result           merged;
    t_result           head;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = full;
    assign accept      = i_in_valid && !full;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= DebounceRst;
            r_step      <= StepRst;
            r_speed_max <= SpeedMaxRst;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DEBOUNCE:  r_debounce  <= i_cfg_data[AgeW-1:0];
                CFG_STEP:      r_step      <= i_cfg_data[StepW-1:0];
                CFG_SPEED_MAX: r_speed_max <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // Debounce lanes, one per button
    for (genvar g = 0; g < Chans; g++) begin : g_lane
        drp_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (accept),
            .i_raw      (i_raw_buttons[g]),
            .i_tick     (i_ms_tick),
            .i_debounce (r_debounce),
            .o_evt      (evt[g])
        );
    end

    // Apply button rules in channel order
    drp_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (accept),
        .i_evt       (evt),
        .i_step      (r_step),
        .i_speed_max (r_speed_max),
        .o_result    (merged)
    );

    // Queue results toward the output
    drp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (merged),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (head)
    );

    assign o_run_enable     = head.run_enable;
    assign o_direction      = head.direction;
    assign o_speed_value    = head.speed_value;
    assign o_stable_buttons = head.stable_buttons;

endmodule

[tb/tb.sv]
// Self-checking testbench for the debounced rotator panel: queued sample driver, result checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import drp_pkg::*;

    // Index that maps to no register
    localparam logic [1:0] CfgUnused = 2'd3;

    typedef struct {
        logic [Chans-1:0] raw;
        logic             tick;
    } t_sample;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic [Chans-1:0]  i_raw_buttons = '0;
    logic              i_ms_tick = 1'b0;
    logic              i_out_stall = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic [1:0]        i_cfg_index = CFG_DEBOUNCE;
    logic [SpeedW-1:0] i_cfg_data = '0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic              o_run_enable;
    logic              o_direction;
    logic [SpeedW-1:0] o_speed_value;
    logic [Chans-1:0]  o_stable_buttons;
    logic              o_cfg_ready;

    debounced_rotator_panel DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_raw_buttons    (i_raw_buttons),
        .i_ms_tick        (i_ms_tick),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_run_enable     (o_run_enable),
        .o_direction      (o_direction),
        .o_speed_value    (o_speed_value),
        .o_stable_buttons (o_stable_buttons),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Panel state mirror and its settings
    logic [AgeW-1:0]   pan_debounce = DebounceRst;
    logic [StepW-1:0]  pan_step     = StepRst;
    logic [SpeedW-1:0] pan_speed_max = SpeedMaxRst;
    logic [Chans-1:0]  pan_prev_raw = '0;
    logic [Chans-1:0]  pan_stable   = '0;
    logic [AgeW-1:0]   pan_age [Chans] = '{default: '0};
    logic [SpeedW-1:0] pan_speed    = '0;
    logic              pan_dir      = 1'b0;
    logic              pan_run      = 1'b1;

    t_sample pending_samples [$];
    t_result panel_expected [$];
    int      samples_queued   = 0;
    int      samples_accepted = 0;
    int      mismatch_count   = 0;

    logic    in_took  = 1'b0;
    logic    out_took = 1'b0;
    bit      in_calm  = 1'b0;
    bit      out_calm = 1'b0;
    int      in_gap   = 0;
    int      out_wait = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Apply the first matching button rule to the current stable levels
    function automatic void apply_button_rule();
        logic [SpeedW:0] sum;
        sum = {1'b0, pan_speed} + {7'd0, pan_step};
        if (!pan_stable[0]) begin
            pan_speed = (sum > {1'b0, pan_speed_max}) ? pan_speed_max : sum[SpeedW-1:0];
        end else if (!pan_stable[1]) begin
            pan_speed = (pan_speed >= {6'd0, pan_step}) ? pan_speed - {6'd0, pan_step} : '0;
        end else if (!pan_stable[2]) begin
            pan_dir = ~pan_dir;
        end else if (!pan_stable[3]) begin
            pan_run = ~pan_run;
        end
    endfunction

    // Advance the panel by one sample and return the result it shows
    function automatic t_result advance_panel(input logic [Chans-1:0] raw, input logic tick);
        t_result r;
        for (int ch = 0; ch < Chans; ch++) begin
            if (raw[ch] != pan_prev_raw[ch])
                pan_age[ch] = '0;
            else if (tick && pan_age[ch] != AgeTop)
                pan_age[ch] = pan_age[ch] + 1'b1;
            if (pan_age[ch] > pan_debounce && raw[ch] != pan_stable[ch]) begin
                pan_stable[ch] = raw[ch];
                apply_button_rule();
            end
            pan_prev_raw[ch] = raw[ch];
        end
        r.run_enable     = pan_run;
        r.direction      = pan_dir;
        r.speed_value    = pan_speed;
        r.stable_buttons = pan_stable;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [SpeedW-1:0] got,
                                   input logic [SpeedW-1:0] want);
        mismatch_count++;
        $display("%0t error: %s got %h want %h", $realtime, field, got, want);
    endtask

    // Check each result beat against the oldest expectation, then predict new samples
    always @(posedge i_clk) begin : check_and_predict
        t_result seen;
        t_result want;
        if (i_rst_n) begin
            out_took <= o_out_valid && !i_out_stall;
            in_took  <= i_in_valid && !o_in_stall;
            if (o_out_valid && !i_out_stall) begin
                seen.run_enable     = o_run_enable;
                seen.direction      = o_direction;
                seen.speed_value    = o_speed_value;
                seen.stable_buttons = o_stable_buttons;
                if (panel_expected.size() == 0) begin
                    report_mismatch("unexpected beat", o_speed_value, '0);
                end else begin
                    want = panel_expected.pop_front();
                    if (seen.run_enable !== want.run_enable)
                        report_mismatch("run_enable", 16'(seen.run_enable),
                                        16'(want.run_enable));
                    if (seen.direction !== want.direction)
                        report_mismatch("direction", 16'(seen.direction),
                                        16'(want.direction));
                    if (seen.speed_value !== want.speed_value)
                        report_mismatch("speed_value", seen.speed_value, want.speed_value);
                    if (seen.stable_buttons !== want.stable_buttons)
                        report_mismatch("stable_buttons", 16'(seen.stable_buttons),
                                        16'(want.stable_buttons));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                panel_expected.push_back(advance_panel(i_raw_buttons, i_ms_tick));
                samples_accepted++;
            end
        end
    end

    // Feed sample beats from the pending queue with random gaps
    always @(negedge i_clk) begin : drive_samples
        t_sample s;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_took) begin
            // hold the stalled beat
        end else if (in_gap != 0) begin
            in_gap        <= in_gap - 1;
            i_in_valid    <= 1'b0;
            i_raw_buttons <= 4'($urandom_range(0, 15));
            i_ms_tick     <= 1'($urandom_range(0, 1));
        end else if (pending_samples.size() != 0) begin
            s = pending_samples.pop_front();
            i_in_valid    <= 1'b1;
            i_raw_buttons <= s.raw;
            i_ms_tick     <= s.tick;
            if ($urandom_range(0, 49) == 0)
                in_calm = !in_calm;
            in_gap <= in_calm ? 0 : $urandom_range(0, 16);
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Stall the result side for a random count after each taken beat
    always @(negedge i_clk) begin : drive_stall
        int w;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            w = out_wait;
            if (out_took) begin
                if ($urandom_range(0, 49) == 0)
                    out_calm = !out_calm;
                w = out_calm ? 0 : $urandom_range(0, 16);
            end
            if (w != 0) begin
                i_out_stall <= 1'b1;
                out_wait    <= w - 1;
            end else begin
                i_out_stall <= 1'b0;
                out_wait    <= 0;
            end
        end
    end

    task automatic push_sample(input logic [Chans-1:0] raw, input logic tick);
        t_sample s;
        s.raw  = raw;
        s.tick = tick;
        pending_samples.push_back(s);
        samples_queued++;
    endtask

    // Drive one register beat and track its effect; valid is lowered by the caller
    task automatic write_reg(input logic [1:0] idx, input logic [SpeedW-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DEBOUNCE:  pan_debounce  = data[AgeW-1:0];
            CFG_STEP:      pan_step      = data[StepW-1:0];
            CFG_SPEED_MAX: pan_speed_max = data;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (samples_accepted != samples_queued || panel_expected.size() != 0);
    endtask

    // Bounce briefly, then hold the target for a given number of ticks
    task automatic queue_gesture(input logic [Chans-1:0] target, input int ticks);
        int n;
        n = $urandom_range(0, 3);
        repeat (n) push_sample(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        while (ticks > 0) begin
            bit t;
            t = ($urandom_range(0, 4) != 0);
            push_sample(target, t);
            if (t)
                ticks--;
        end
    endtask

    // Mostly well-formed presses and releases, some noise and cut-short holds
    task automatic run_gestures(input int budget);
        int stop_at;
        int pick;
        int hold;
        stop_at = samples_queued + budget;
        while (samples_queued < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pan_debounce > 40)
                hold = $urandom_range(5, 40);
            else
                hold = pan_debounce + 2 + $urandom_range(0, 2);
            if (pick == 0)
                repeat ($urandom_range(1, 5))
                    push_sample(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            else if (pick == 1)
                queue_gesture(4'($urandom_range(0, 15)), $urandom_range(0, pan_debounce));
            else
                queue_gesture(4'($urandom_range(0, 15)), hold);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: fastest debounce, largest step
        write_reg(CFG_DEBOUNCE, 16'h0000);
        write_reg(CFG_STEP, 16'hFFFF);
        write_reg(CfgUnused, 16'($urandom_range(0, 65535)));
        end_writes();
        push_sample(4'hF, 1'b1);   // change with tick: age stays zero
        push_sample(4'hF, 1'b0);
        push_sample(4'hF, 1'b1);   // releases of all four act in channel order
        push_sample(4'hE, 1'b1);
        push_sample(4'hE, 1'b1);   // up press
        push_sample(4'hD, 1'b0);
        push_sample(4'hD, 1'b1);   // release 0, press 1 in one sample
        push_sample(4'hB, 1'b1);
        push_sample(4'hB, 1'b1);   // direction
        push_sample(4'h7, 1'b1);
        push_sample(4'h7, 1'b1);   // run
        push_sample(4'h0, 1'b1);
        push_sample(4'h0, 1'b1);   // all pressed at once
        push_sample(4'h0, 1'b0);
        push_sample(4'hF, 1'b0);
        push_sample(4'hF, 1'b1);
        push_sample(4'h5, 1'b1);
        push_sample(4'hA, 1'b1);
        push_sample(4'hA, 1'b1);
        push_sample(4'hF, 1'b1);
        push_sample(4'hF, 1'b1);
        wait_drained();

        // Short debounce, random step, full speed range
        write_reg(CFG_DEBOUNCE, 16'({$urandom_range(0, 255), 8'd0} | $urandom_range(0, 4)));
        write_reg(CFG_STEP, 16'({$urandom_range(0, 63), 10'd0} | $urandom_range(1, 1023)));
        write_reg(CFG_SPEED_MAX, 16'hFFFF);
        end_writes();
        run_gestures(300);
        wait_drained();

        // Lowered speed limit: speed above it clips on the next up press
        write_reg(CFG_SPEED_MAX, 16'h0000);
        write_reg(CFG_DEBOUNCE, 16'd2);
        end_writes();
        run_gestures(60);
        wait_drained();
        write_reg(CFG_SPEED_MAX, 16'($urandom_range(1, 300)));
        write_reg(CFG_STEP, 16'($urandom_range(1, 120)));
        end_writes();
        run_gestures(200);
        wait_drained();

        // Step of zero after masking: down presses leave speed alone, up presses only clip it to the limit
        write_reg(CFG_STEP, 16'({$urandom_range(0, 63), 10'd0}));
        write_reg(CFG_DEBOUNCE, 16'd1);
        write_reg(CFG_SPEED_MAX, 16'($urandom_range(0, 65535)));
        end_writes();
        run_gestures(150);
        wait_drained();

        // Debounce at its top: stable levels never move
        write_reg(CFG_DEBOUNCE, 16'({$urandom_range(0, 255), 8'hFF}));
        end_writes();
        run_gestures(100);
        wait_drained();

        // Reset-style settings
        write_reg(CFG_DEBOUNCE, 16'd20);
        write_reg(CFG_STEP, 16'd30);
        write_reg(CFG_SPEED_MAX, 16'hFFFF);
        end_writes();
        run_gestures(200);
        wait_drained();

        // Largest usable debounce: age must saturate before a change lands
        write_reg(CFG_DEBOUNCE, 16'd254);
        write_reg(CFG_STEP, 16'd1023);
        end_writes();
        queue_gesture(~pan_stable, 258);
        wait_drained();

        repeat (5) @(negedge i_clk);
        if (panel_expected.size() != 0)
            report_mismatch("missing beats", 16'(panel_expected.size()), '0);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
